>>> sv/fr_pkg.sv
package fr_pkg;

  // Default word width of the fraction parts
  localparam int FR_WORD_BITS = 32;

  // Result status codes
  localparam logic FR_OK       = 1'b0;
  localparam logic FR_DEN_ZERO = 1'b1;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT,
    ST_GCD,
    ST_DIVN,
    ST_DSTART,
    ST_DIVD,
    ST_DONE
  } fr_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;         // capture transaction, take magnitudes
    logic set_special;  // zero numerator or zero denominator result
    logic shift_step;   // strip one common factor of two
    logic gcd_step;     // one binary GCD step
    logic g_load;       // latch gcd, start numerator division
    logic div_start_d;  // start denominator division
    logic div_step;     // one restoring division step
    logic store_qn;     // keep signed numerator quotient
    logic store_qd;     // keep signed denominator quotient
    logic out_load;     // move result into output register
  } fr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic den_zero;
    logic num_zero;
    logic both_even;
    logic ab_equal;
    logic div_last;
    logic out_free;
  } fr_stat_t;

endpackage

>>> sv/fr_ctrl.sv
module fr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fr_pkg::fr_stat_t stat,
  output fr_pkg::fr_cmd_t  cmd
);
  import fr_pkg::*;

  fr_state_t state_r;
  fr_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.den_zero || stat.num_zero) state_nxt = ST_DONE;
        else state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!stat.both_even) state_nxt = ST_GCD;
      end
      ST_GCD: begin
        if (stat.ab_equal) state_nxt = ST_DIVN;
      end
      ST_DIVN: begin
        if (stat.div_last) state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        state_nxt = ST_DIVD;
      end
      ST_DIVD: begin
        if (stat.div_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_CHECK: begin
        cmd.set_special = stat.den_zero || stat.num_zero;
      end
      ST_SHIFT: begin
        cmd.shift_step = stat.both_even;
      end
      ST_GCD: begin
        cmd.gcd_step = !stat.ab_equal;
        cmd.g_load   = stat.ab_equal;
      end
      ST_DIVN: begin
        cmd.div_step = 1'b1;
        cmd.store_qn = stat.div_last;
      end
      ST_DSTART: begin
        cmd.div_start_d = 1'b1;
      end
      ST_DIVD: begin
        cmd.div_step = 1'b1;
        cmd.store_qd = stat.div_last;
      end
      ST_DONE: begin
        cmd.out_load = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> sv/fr_datapath.sv
module fr_datapath #(
  parameter int WORD_BITS = fr_pkg::FR_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic signed [WORD_BITS-1:0] in_numerator,
  input  logic signed [WORD_BITS-1:0] in_denominator,
  input  fr_pkg::fr_cmd_t             cmd,
  output fr_pkg::fr_stat_t            stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_reduced_numerator,
  output logic signed [WORD_BITS-1:0] out_reduced_denominator,
  output logic                        out_status
);
  import fr_pkg::*;

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST_STEP = CW'(WORD_BITS - 1);

  // Captured transaction
  logic [WORD_BITS-1:0] n_raw_r, d_raw_r, n_raw_nxt, d_raw_nxt;
  logic                 nneg_r, dneg_r, nneg_nxt, dneg_nxt;
  logic [WORD_BITS-1:0] nmag_r, dmag_r, nmag_nxt, dmag_nxt;
  // GCD working pair and common shift
  logic [WORD_BITS-1:0] a_r, b_r, a_nxt, b_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [WORD_BITS-1:0] g_r, g_nxt;
  // Restoring divider
  logic [WORD_BITS-1:0] rem_r, rem_nxt, quo_r, quo_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  // Result holding and output registers
  logic [WORD_BITS-1:0] res_n_r, res_d_r, res_n_nxt, res_d_nxt;
  logic                 res_st_r, res_st_nxt;
  logic [WORD_BITS-1:0] on_r, od_r, on_nxt, od_nxt;
  logic                 ost_r, ost_nxt;
  logic                 ovalid_r, ovalid_nxt;

  logic [WORD_BITS:0]   rem_sh, rem_sub;
  logic                 q_bit;
  logic [WORD_BITS-1:0] rem_step, quo_step;
  logic [WORD_BITS-1:0] a_minus_b, b_minus_a;

  function automatic logic [WORD_BITS-1:0] neg_word(input logic [WORD_BITS-1:0] v);
    neg_word = ~v + {{(WORD_BITS-1){1'b0}}, 1'b1};
  endfunction

  // One restoring division step
  always_comb begin
    rem_sh   = {rem_r, quo_r[WORD_BITS-1]};
    rem_sub  = rem_sh - {1'b0, g_r};
    q_bit    = !rem_sub[WORD_BITS];
    rem_step = q_bit ? rem_sub[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    quo_step = {quo_r[WORD_BITS-2:0], q_bit};
  end

  assign a_minus_b = a_r - b_r;
  assign b_minus_a = b_r - a_r;

  // Next values
  always_comb begin
    n_raw_nxt  = n_raw_r;
    d_raw_nxt  = d_raw_r;
    nneg_nxt   = nneg_r;
    dneg_nxt   = dneg_r;
    nmag_nxt   = nmag_r;
    dmag_nxt   = dmag_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    k_nxt      = k_r;
    g_nxt      = g_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    res_n_nxt  = res_n_r;
    res_d_nxt  = res_d_r;
    res_st_nxt = res_st_r;
    on_nxt     = on_r;
    od_nxt     = od_r;
    ost_nxt    = ost_r;
    ovalid_nxt = ovalid_r;

    // capture transaction and magnitudes
    if (cmd.load) begin
      n_raw_nxt = in_numerator;
      d_raw_nxt = in_denominator;
      nneg_nxt  = in_numerator[WORD_BITS-1];
      dneg_nxt  = in_denominator[WORD_BITS-1];
      nmag_nxt  = in_numerator[WORD_BITS-1] ? neg_word(in_numerator) : in_numerator;
      dmag_nxt  = in_denominator[WORD_BITS-1] ? neg_word(in_denominator) : in_denominator;
      a_nxt     = nmag_nxt;
      b_nxt     = dmag_nxt;
      k_nxt     = '0;
    end

    // zero denominator passes through, zero numerator gives 0/1
    if (cmd.set_special) begin
      if (b_r == '0) begin
        res_n_nxt  = n_raw_r;
        res_d_nxt  = d_raw_r;
        res_st_nxt = FR_DEN_ZERO;
      end else begin
        res_n_nxt  = '0;
        res_d_nxt  = {{(WORD_BITS-1){1'b0}}, 1'b1};
        res_st_nxt = FR_OK;
      end
    end

    // common powers of two
    if (cmd.shift_step) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + 1'b1;
    end

    // binary GCD step
    if (cmd.gcd_step) begin
      if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = a_minus_b >> 1;
      end else begin
        b_nxt = b_minus_a >> 1;
      end
    end

    // gcd ready: start numerator division
    if (cmd.g_load) begin
      g_nxt   = a_r << k_r;
      rem_nxt = '0;
      quo_nxt = nmag_r;
      cnt_nxt = '0;
    end

    if (cmd.div_start_d) begin
      rem_nxt = '0;
      quo_nxt = dmag_r;
      cnt_nxt = '0;
    end

    if (cmd.div_step) begin
      rem_nxt = rem_step;
      quo_nxt = quo_step;
      cnt_nxt = cnt_r + 1'b1;
    end

    // signed quotients
    if (cmd.store_qn) begin
      res_n_nxt  = nneg_r ? neg_word(quo_step) : quo_step;
      res_st_nxt = FR_OK;
    end
    if (cmd.store_qd) begin
      res_d_nxt = dneg_r ? neg_word(quo_step) : quo_step;
    end

    // output register
    if (ovalid_r && !out_stall) ovalid_nxt = 1'b0;
    if (cmd.out_load) begin
      on_nxt     = res_n_r;
      od_nxt     = res_d_r;
      ost_nxt    = res_st_r;
      ovalid_nxt = 1'b1;
    end
  end

  // Control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    n_raw_r  <= n_raw_nxt;
    d_raw_r  <= d_raw_nxt;
    nneg_r   <= nneg_nxt;
    dneg_r   <= dneg_nxt;
    nmag_r   <= nmag_nxt;
    dmag_r   <= dmag_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    k_r      <= k_nxt;
    g_r      <= g_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    cnt_r    <= cnt_nxt;
    res_n_r  <= res_n_nxt;
    res_d_r  <= res_d_nxt;
    res_st_r <= res_st_nxt;
    on_r     <= on_nxt;
    od_r     <= od_nxt;
    ost_r    <= ost_nxt;
  end

  // Status
  always_comb begin
    stat.den_zero  = (b_r == '0);
    stat.num_zero  = (a_r == '0);
    stat.both_even = !a_r[0] && !b_r[0];
    stat.ab_equal  = (a_r == b_r);
    stat.div_last  = (cnt_r == LAST_STEP);
    stat.out_free  = !ovalid_r || !out_stall;
  end

  assign out_valid               = ovalid_r;
  assign out_reduced_numerator   = on_r;
  assign out_reduced_denominator = od_r;
  assign out_status              = ost_r;

  // A finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!ovalid_r || !out_stall))
    else $error("result loaded over a pending transaction");

  // GCD search only runs on a nonzero pair
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.gcd_step || cmd.shift_step) |-> (a_r != '0 && b_r != '0))
    else $error("gcd step on zero operand");

  // Divisor is never zero once latched
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (g_r != '0))
    else $error("division by zero gcd");

  // Partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> (rem_r < g_r))
    else $error("partial remainder out of range");

endmodule

>>> sv/fraction_reducer_core.sv
// A transaction is captured, checked for a zero numerator or denominator, stripped of its
// common factors of two and reduced by binary GCD steps; then the single restoring divider
// divides each part by the gcd in turn. A zero numerator or denominator goes straight to
// the result. Only one transaction is worked on at a time, in the shared GCD unit and the
// divider; no new input is taken until its result has moved into the output register, but
// the next input is taken while a result waits there. Reset: synchronous, active-low rst_n;
// clears the controller to idle and out_valid, data registers are not reset.
module fraction_reducer_core #(
  parameter int WORD_BITS = fr_pkg::FR_WORD_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] in_numerator,
  input  logic signed [WORD_BITS-1:0] in_denominator,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_reduced_numerator,
  output logic signed [WORD_BITS-1:0] out_reduced_denominator,
  output logic                        out_status
);
  import fr_pkg::*;

  fr_cmd_t  cmd;
  fr_stat_t stat;

  // Sequencer
  fr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // GCD and divider datapath
  fr_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_numerator            (in_numerator),
    .in_denominator          (in_denominator),
    .cmd                     (cmd),
    .stat                    (stat),
    .out_valid               (out_valid),
    .out_stall               (out_stall),
    .out_reduced_numerator   (out_reduced_numerator),
    .out_reduced_denominator (out_reduced_denominator),
    .out_status              (out_status)
  );

endmodule

>>> dv/tb_fraction_reducer_core.sv
module tb_fraction_reducer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import fr_pkg::*;

  localparam int WORD_BITS = FR_WORD_BITS;
  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM = 750;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 250;
  localparam int MAX_REPORTS = 10;

  typedef logic [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [WORD_BITS-1:0] numer;
    logic signed [WORD_BITS-1:0] denom;
    logic                        status;
  } fraction_t;

  typedef struct {
    logic signed [WORD_BITS-1:0] numer;
    logic signed [WORD_BITS-1:0] denom;
    bit                          fixed_result;
    fraction_t                   result;
  } directed_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [WORD_BITS-1:0] in_numerator;
  logic signed [WORD_BITS-1:0] in_denominator;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [WORD_BITS-1:0] out_reduced_numerator;
  logic signed [WORD_BITS-1:0] out_reduced_denominator;
  logic                        out_status;

  fraction_t expected_fractions[$];
  directed_row_t directed_rows[NUM_DIRECTED];

  int  mismatch_count;
  int  fractions_sent;
  int  results_checked;
  int  zero_den_results;
  int  zero_num_results;
  int  idle_cycles;
  bit  quiet_phase;

  fraction_reducer_core #(.WORD_BITS(WORD_BITS)) dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_numerator           (in_numerator),
    .in_denominator         (in_denominator),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_reduced_numerator  (out_reduced_numerator),
    .out_reduced_denominator(out_reduced_denominator),
    .out_status             (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Lowest terms of num/den: gcd of the magnitudes, each part keeps its sign
  function automatic fraction_t reduce_fraction(word_t num, word_t den);
    fraction_t r;
    word_t nmag, dmag, a, b, rem;
    bit nneg, dneg;
    nneg = num[WORD_BITS-1];
    dneg = den[WORD_BITS-1];
    nmag = nneg ? word_t'(-num) : num;
    dmag = dneg ? word_t'(-den) : den;
    if (dmag == '0) begin
      // zero denominator: pass both parts through
      r.numer = num;
      r.denom = den;
      r.status = FR_DEN_ZERO;
    end else if (nmag == '0) begin
      r.numer = '0;
      r.denom = 1;
      r.status = FR_OK;
    end else begin
      a = nmag;
      b = dmag;
      while (b != '0) begin
        rem = a % b;
        a = b;
        b = rem;
      end
      r.numer = nneg ? word_t'(-(nmag / a)) : nmag / a;
      r.denom = dneg ? word_t'(-(dmag / a)) : dmag / a;
      r.status = FR_OK;
    end
    return r;
  endfunction

  // Any word inside the symmetric input range
  function automatic word_t rand_word();
    word_t v;
    do v = $urandom; while (v == WORD_MIN);
    return v;
  endfunction

  function automatic word_t with_rand_sign(word_t mag);
    return $urandom_range(0, 1) ? word_t'(-mag) : mag;
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(0, 6))
      0: return WORD_MAX;
      1: return word_t'(-WORD_MAX);
      2: return 1;
      3: return word_t'(-1);
      4: return '0;
      5: return word_t'(1) << (WORD_BITS - 2);
      default: return word_t'(-(word_t'(1) << (WORD_BITS - 2)));
    endcase
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Offer one fraction, record its expected result once accepted
  task automatic send_fraction(input word_t num, input word_t den, input bit fixed_result,
                               input fraction_t fixed, input int gap);
    in_valid <= 1'b1;
    in_numerator <= num;
    in_denominator <= den;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_fractions.push_back(fixed_result ? fixed : reduce_fraction(num, den));
    fractions_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender: directed table, then random fractions
  initial begin
    word_t num, den, g;
    int gap;
    fraction_t no_result;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_numerator = '0;
    in_denominator = '0;
    quiet_phase = 1'b0;
    no_result = '{'0, '0, FR_OK};
    directed_rows = '{
      '{0, 0, 1'b1, '{0, 0, FR_DEN_ZERO}},
      '{5, 0, 1'b1, '{5, 0, FR_DEN_ZERO}},
      '{-WORD_MAX, 0, 1'b1, '{-WORD_MAX, 0, FR_DEN_ZERO}},
      '{WORD_MAX, 0, 1'b1, '{WORD_MAX, 0, FR_DEN_ZERO}},
      '{0, 7, 1'b1, '{0, 1, FR_OK}},
      '{0, -WORD_MAX, 1'b1, '{0, 1, FR_OK}},
      '{0, WORD_MAX, 1'b1, '{0, 1, FR_OK}},
      '{1, 1, 1'b1, '{1, 1, FR_OK}},
      '{-1, -1, 1'b1, '{-1, -1, FR_OK}},
      '{WORD_MAX, WORD_MAX, 1'b1, '{1, 1, FR_OK}},
      '{-WORD_MAX, WORD_MAX, 1'b1, '{-1, 1, FR_OK}},
      '{WORD_MAX, -WORD_MAX, 1'b1, '{1, -1, FR_OK}},
      '{-WORD_MAX, -WORD_MAX, 1'b1, '{-1, -1, FR_OK}},
      '{WORD_MAX, 1, 1'b1, '{WORD_MAX, 1, FR_OK}},
      '{-1, WORD_MAX, 1'b1, '{-1, WORD_MAX, FR_OK}},
      '{6, 4, 1'b0, no_result},
      '{-12, 18, 1'b0, no_result},
      '{1073741824, 536870912, 1'b0, no_result},
      '{1073741824, -1073741824, 1'b0, no_result},
      '{2147483646, 1073741823, 1'b0, no_result},
      '{2147483629, 2147483587, 1'b0, no_result},
      '{1234567890, -987654321, 1'b0, no_result},
      '{196608, 327680, 1'b0, no_result},
      '{-1431655765, 715827882, 1'b0, no_result}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_fraction(directed_rows[i].numer, directed_rows[i].denom,
                    directed_rows[i].fixed_result, directed_rows[i].result, pick_gap());

    for (int i = 0; i < NUM_RANDOM; i++) begin
      quiet_phase = (i >= 450 && i < 530);
      case ($urandom_range(0, 9))
        0, 1: begin
          num = rand_word();
          den = rand_word();
        end
        2: begin
          num = with_rand_sign($urandom_range(0, 100));
          den = with_rand_sign($urandom_range(0, 100));
        end
        3, 4, 5: begin
          // shared odd or even factor up to 16 bits
          g = $urandom_range(1, 65535);
          num = with_rand_sign(word_t'($urandom_range(0, 32767)) * g);
          den = with_rand_sign(word_t'($urandom_range(1, 32767)) * g);
        end
        6: begin
          // many common factors of two
          num = with_rand_sign(word_t'($urandom_range(1, 65535)) << $urandom_range(0, 15));
          den = with_rand_sign(word_t'($urandom_range(1, 65535)) << $urandom_range(0, 15));
        end
        7: begin
          num = $urandom_range(0, 1) ? rand_word() : '0;
          den = '0;
          if ($urandom_range(0, 1)) begin
            den = num;
            num = '0;
            if (den == '0) den = 1;
          end
        end
        8: begin
          num = pick_extreme();
          den = pick_extreme();
        end
        default: begin
          num = rand_word();
          den = $urandom_range(0, 1) ? with_rand_sign(num) : word_t'(1);
        end
      endcase
      gap = quiet_phase ? 0 : pick_gap();
      send_fraction(num, den, 1'b0, no_result, gap);
      if (i == 200 || i == 600) begin
        // hold off until the block has handed back everything
        in_valid <= 1'b0;
        while (expected_fractions.size() != 0) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    while (expected_fractions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d fractions (%0d from the directed table), %0d results checked",
             fractions_sent, NUM_DIRECTED, results_checked);
    $display("  %0d zero-denominator and %0d zero-numerator results, %0d mismatches",
             zero_den_results, zero_num_results, mismatch_count);
    if (mismatch_count == 0 && expected_fractions.size() == 0)
      $display("tb_fraction_reducer_core: clean");
    else
      $display("tb_fraction_reducer_core: errors");
    $finish;
  end

  // Receiver: random stall bursts, none during the quiet window
  initial begin
    int run, gap;
    out_stall = 1'b0;
    forever begin
      run = quiet_phase ? 1 : $urandom_range(1, 12);
      out_stall <= 1'b0;
      repeat (run) @(posedge clk);
      gap = quiet_phase ? 0 : pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Result check against the oldest expectation, plus idle tracking
  always @(posedge clk) begin : result_check
    fraction_t exp_f;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (out_status == FR_DEN_ZERO) zero_den_results++;
      else if (out_reduced_numerator == 0) zero_num_results++;
      if (expected_fractions.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result %0d/%0d status %0d with no transaction pending", $realtime,
                   out_reduced_numerator, out_reduced_denominator, out_status);
        mismatch_count++;
      end else begin
        exp_f = expected_fractions.pop_front();
        if (out_reduced_numerator !== exp_f.numer || out_reduced_denominator !== exp_f.denom ||
            out_status !== exp_f.status) begin
          if (mismatch_count < MAX_REPORTS)
            $display("%0t: expected %0d/%0d status %0d, got %0d/%0d status %0d", $realtime,
                     exp_f.numer, exp_f.denom, exp_f.status, out_reduced_numerator,
                     out_reduced_denominator, out_status);
          mismatch_count++;
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // Watchdog: too long without any transaction on either side
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, expected_fractions.size());
    $display("tb_fraction_reducer_core: errors");
    $finish;
  end

endmodule

>>> fraction_reducer_core.f
sv/fr_pkg.sv
sv/fr_ctrl.sv
sv/fr_datapath.sv
sv/fraction_reducer_core.sv
dv/tb_fraction_reducer_core.sv
